### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl files
// clocked assertion with asynchronous reset disable, and a never-true variant
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hw/rtl/tsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_pkg
// shared sizes, codes and types of the tabulated spectrum interpolator
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int ENERGY_BITS  = 32;
    localparam int DENSITY_BITS = 32;

    localparam int ISOTOPES   = 3;
    localparam int NODES      = ISOTOPES * TABLE_DEPTH;
    localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_BITS  = $clog2(NODES);
    localparam int PROD_BITS  = ENERGY_BITS + DENSITY_BITS;
    localparam int STEP_BITS  = $clog2(PROD_BITS + 1);

    // fixed port widths
    localparam int PORT_W     = 32;
    localparam int IDX_PORT_W = 10;
    localparam int ISO_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // request function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // isotope codes
    localparam logic [ISO_W-1:0] ISO_K40   = 2'd0;
    localparam logic [ISO_W-1:0] ISO_TH232 = 2'd1;
    localparam logic [ISO_W-1:0] ISO_U238  = 2'd2;
    localparam logic [ISO_W-1:0] ISO_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POTASSIUM_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THORIUM_ENTRIES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_URANIUM_ENTRIES   = 2'd2;

    // status of the serial multiply-divide unit
    typedef struct packed {
        logic                    done;
        logic                    big;
        logic [DENSITY_BITS-1:0] quot;
    } muldiv_res_t;

endpackage

### hw/rtl/tsi_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_muldiv
// bit-serial multiply then restoring divide: (mcand * mplier) / divisor
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsi_muldiv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [tsi_pkg::DENSITY_BITS-1:0]   mcand,
    input  logic [tsi_pkg::ENERGY_BITS-1:0]    mplier,
    input  logic [tsi_pkg::ENERGY_BITS-1:0]    divisor,
    output tsi_pkg::muldiv_res_t               res
);

    localparam int EB = tsi_pkg::ENERGY_BITS;
    localparam int DB = tsi_pkg::DENSITY_BITS;
    localparam int PW = tsi_pkg::PROD_BITS;
    localparam int SW = tsi_pkg::STEP_BITS;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } md_state_t;

    md_state_t       state_reg;
    logic [SW-1:0]   cnt_reg;
    logic [PW-1:0]   prod_reg;
    logic [DB-1:0]   mcand_reg;
    logic [EB-1:0]   div_reg;
    logic [EB-1:0]   rem_reg;
    logic [DB:0]     q_reg;
    logic            ovf_reg;
    logic            done_reg;

    logic [DB:0]     mul_sum;
    logic [PW-1:0]   prod_next;
    logic [EB:0]     shifted;
    logic [EB+1:0]   trial;
    logic            qbit;
    logic [EB-1:0]   rem_next;

    // multiply: add into the upper half, shift right
    always_comb
    begin
        mul_sum   = {1'b0, prod_reg[PW-1:EB]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {mul_sum, prod_reg[EB-1:1]};
    end

    // divide: one quotient bit per cycle, product streamed msb first
    always_comb
    begin
        shifted  = {rem_reg, prod_reg[PW-1]};
        trial    = {1'b0, shifted} - {2'b00, div_reg};
        qbit     = !trial[EB+1];
        rem_next = qbit ? trial[EB-1:0] : shifted[EB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            q_reg     <= '0;
            prod_reg  <= '0;
            mcand_reg <= '0;
            div_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        prod_reg  <= PW'(mplier);
                        mcand_reg <= mcand;
                        div_reg   <= divisor;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        ovf_reg   <= 1'b0;
                        cnt_reg   <= SW'(EB - 1);
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    prod_reg <= prod_next;
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= SW'(PW - 1);
                        state_reg <= M_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - SW'(1);
                    end
                end
                M_DIV:
                begin
                    prod_reg <= {prod_reg[PW-2:0], 1'b0};
                    rem_reg  <= rem_next;
                    q_reg    <= {q_reg[DB-1:0], qbit};
                    ovf_reg  <= ovf_reg | q_reg[DB];
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - SW'(1);
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.big  = ovf_reg | q_reg[DB];
    assign res.quot = q_reg[DB-1:0];

    `ASSERT_CLK(a_rem_below_div, clk, rst_n, (state_reg == M_DIV) |-> (rem_reg < div_reg), "remainder not below divisor")
    `ASSERT_CLK(a_start_idle, clk, rst_n, start |-> (state_reg == M_IDLE), "start while unit busy")
    `ASSERT_CLK(a_done_from_div, clk, rst_n, done_reg |-> ($past(state_reg) == M_DIV), "done without a divide")

endmodule

### hw/rtl/tabulated_spectrum_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabulated_spectrum_interpolator
// three tabulated spectra with lower-bound search and linear interpolation
// ----------------------------------------------------------------------------
// a request is taken on a clock edge with start high and busy low. a load
// request for isotope codes zero to two writes one node in that edge; no load
// raises busy. a lookup holds busy until its single result leaves: density and
// hit appear for exactly one cycle with done high, and the receiver cannot
// stall them, so it must take the result in that cycle. lookup time is set by
// the single read port of the node memories and the bit-serial arithmetic
// unit: a read and a compare per binary search step (up to ceil(log2(count+1))
// steps, 11 for a full table), a fetch and difference of the two bracketing
// nodes, a multiply over the ENERGY_BITS multiplier bits and a divide over the
// ENERGY_BITS + DENSITY_BITS product bits. a query at or below the first node
// or above the last, or an empty table, answers without the arithmetic;
// isotope code three answers straight from idle. the node memories need no
// clearing pass. count registers are written over the cfg port, always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tabulated_spectrum_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    // request side
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic [tsi_pkg::ISO_W-1:0]           isotope,
    input  logic                                flavor,
    input  logic [tsi_pkg::IDX_PORT_W-1:0]      entry_index,
    input  logic [tsi_pkg::PORT_W-1:0]          energy,
    input  logic [tsi_pkg::PORT_W-1:0]          neutrino_density,
    input  logic [tsi_pkg::PORT_W-1:0]          antineutrino_density,
    // result side
    output logic                                done,
    output logic [tsi_pkg::PORT_W-1:0]          density,
    output logic                                hit,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int EB    = tsi_pkg::ENERGY_BITS;
    localparam int DB    = tsi_pkg::DENSITY_BITS;
    localparam int IW    = tsi_pkg::IDX_BITS;
    localparam int NW    = tsi_pkg::CNT_W;
    localparam int AW    = tsi_pkg::ADDR_BITS;
    localparam int DEPTH = tsi_pkg::TABLE_DEPTH;
    localparam int NODES = tsi_pkg::NODES;
    localparam int CW    = tsi_pkg::CFG_DATA_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_CHECK,
        S_FETCH_HI,
        S_FETCH_LO,
        S_DIFF,
        S_START,
        S_WAIT,
        S_FINAL
    } state_t;

    // flat node address: isotope bank plus node position
    function automatic logic [AW-1:0] node_addr(input logic [tsi_pkg::ISO_W-1:0] iso,
                                                input logic [IW-1:0] idx);
        logic [AW-1:0] addr;
        begin
            unique case (iso)
                tsi_pkg::ISO_K40:   addr = AW'(idx);
                tsi_pkg::ISO_TH232: addr = AW'(idx) + AW'(DEPTH);
                tsi_pkg::ISO_U238:  addr = AW'(idx) + AW'(2 * DEPTH);
                default:            addr = '0;
            endcase
            return addr;
        end
    endfunction

    // node memories, one word per node, no reset
    logic [EB-1:0] energy_mem       [NODES];
    logic [DB-1:0] neutrino_mem     [NODES];
    logic [DB-1:0] antineutrino_mem [NODES];

    // count registers
    logic [CW-1:0] k_entries_reg;
    logic [CW-1:0] th_entries_reg;
    logic [CW-1:0] u_entries_reg;

    // control and datapath registers
    state_t                      state_reg;
    logic [tsi_pkg::ISO_W-1:0]   iso_reg;
    logic                        flavor_reg;
    logic [EB-1:0]               e_reg;
    logic [NW-1:0]               n_reg;
    logic [NW-1:0]               first_reg;
    logic [NW-1:0]               count_reg;
    logic [EB-1:0]               x2_reg;
    logic [DB-1:0]               y2_reg;
    logic [DB-1:0]               y1_reg;
    logic [DB-1:0]               dy_reg;
    logic [EB-1:0]               num_reg;
    logic [EB-1:0]               den_reg;
    logic                        neg_reg;
    logic                        qz_reg;
    logic                        done_reg;
    logic [DB-1:0]               density_reg;
    logic                        hit_reg;

    // memory read data
    logic [EB-1:0]               e_rd_reg;
    logic [DB-1:0]               nu_rd_reg;
    logic [DB-1:0]               anu_rd_reg;

    logic                        accept;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic [CW-1:0]               cnt_sel;
    logic [NW-1:0]               n_sel;
    logic [NW-1:0]               half;
    logic [NW-1:0]               mid;
    logic                        less;
    logic [NW-1:0]               first_new;
    logic [NW-1:0]               count_new;
    logic [DB-1:0]               y1_sel;
    logic [DB:0]                 q_ext;
    logic                        q_big;
    logic [DB:0]                 sum;
    logic [DB:0]                 diff;
    logic [DB-1:0]               res_val;
    logic                        md_start;
    tsi_pkg::muldiv_res_t        md_res;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // load request: valid isotope and a position inside the table
    assign wr_en   = accept && (func == tsi_pkg::FUNC_LOAD) && (isotope != tsi_pkg::ISO_NONE)
                     && (32'(entry_index) < 32'(DEPTH));
    assign wr_addr = node_addr(isotope, IW'(entry_index));

    // node count of the requested isotope, clamped to the table depth
    always_comb
    begin
        unique case (isotope)
            tsi_pkg::ISO_K40:   cnt_sel = k_entries_reg;
            tsi_pkg::ISO_TH232: cnt_sel = th_entries_reg;
            tsi_pkg::ISO_U238:  cnt_sel = u_entries_reg;
            default:            cnt_sel = '0;
        endcase
        if (32'(cnt_sel) > 32'(DEPTH))
            n_sel = NW'(DEPTH);
        else
            n_sel = NW'(cnt_sel);
    end

    // lower-bound search step
    always_comb
    begin
        half = count_reg >> 1;
        mid  = first_reg + half;
        less = (e_rd_reg < e_reg);
        if (less)
        begin
            first_new = mid + NW'(1);
            count_new = count_reg - half - NW'(1);
        end
        else
        begin
            first_new = first_reg;
            count_new = half;
        end
    end

    // read address per phase
    always_comb
    begin
        unique case (state_reg)
            S_SEARCH_RD: rd_addr = node_addr(iso_reg, IW'(mid));
            S_FETCH_HI:  rd_addr = node_addr(iso_reg, IW'(first_reg));
            S_FETCH_LO:  rd_addr = node_addr(iso_reg, IW'(first_reg - NW'(1)));
            default:     rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            energy_mem[wr_addr]       <= EB'(energy);
            neutrino_mem[wr_addr]     <= DB'(neutrino_density);
            antineutrino_mem[wr_addr] <= DB'(antineutrino_density);
        end
        e_rd_reg   <= energy_mem[rd_addr];
        nu_rd_reg  <= neutrino_mem[rd_addr];
        anu_rd_reg <= antineutrino_mem[rd_addr];
    end

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_entries_reg  <= '0;
            th_entries_reg <= '0;
            u_entries_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tsi_pkg::REG_POTASSIUM_ENTRIES: k_entries_reg  <= cfg_data;
                tsi_pkg::REG_THORIUM_ENTRIES:   th_entries_reg <= cfg_data;
                tsi_pkg::REG_URANIUM_ENTRIES:   u_entries_reg  <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // lower bracketing node column
    assign y1_sel = flavor_reg ? anu_rd_reg : nu_rd_reg;

    // slope times offset over span
    assign md_start = (state_reg == S_START) && (den_reg != '0);

    tsi_muldiv u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .mcand   (dy_reg),
        .mplier  (num_reg),
        .divisor (den_reg),
        .res     (md_res)
    );

    // apply the signed quotient to y1 and saturate
    always_comb
    begin
        q_ext = qz_reg ? '0 : {1'b0, md_res.quot};
        q_big = !qz_reg && md_res.big;
        sum   = {1'b0, y1_reg} + q_ext;
        diff  = {1'b0, y1_reg} - q_ext;
        if (neg_reg)
            res_val = (q_big || diff[DB]) ? '0 : diff[DB-1:0];
        else
            res_val = (q_big || sum[DB]) ? '1 : sum[DB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            density_reg <= '0;
            hit_reg     <= 1'b0;
            iso_reg     <= '0;
            flavor_reg  <= 1'b0;
            e_reg       <= '0;
            n_reg       <= '0;
            first_reg   <= '0;
            count_reg   <= '0;
            x2_reg      <= '0;
            y2_reg      <= '0;
            y1_reg      <= '0;
            dy_reg      <= '0;
            num_reg     <= '0;
            den_reg     <= '0;
            neg_reg     <= 1'b0;
            qz_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (func == tsi_pkg::FUNC_LOOKUP))
                    begin
                        if (isotope == tsi_pkg::ISO_NONE)
                        begin
                            // no such table: empty answer right away
                            done_reg    <= 1'b1;
                            density_reg <= '0;
                            hit_reg     <= 1'b0;
                        end
                        else
                        begin
                            iso_reg    <= isotope;
                            flavor_reg <= flavor;
                            e_reg      <= EB'(energy);
                            n_reg      <= n_sel;
                            first_reg  <= '0;
                            count_reg  <= n_sel;
                            state_reg  <= (n_sel == '0) ? S_CHECK : S_SEARCH_RD;
                        end
                    end
                end
                S_SEARCH_RD:
                begin
                    state_reg <= S_SEARCH_CMP;
                end
                S_SEARCH_CMP:
                begin
                    first_reg <= first_new;
                    count_reg <= count_new;
                    state_reg <= (count_new == '0) ? S_CHECK : S_SEARCH_RD;
                end
                S_CHECK:
                begin
                    // at or below the first node, or past the last
                    if ((first_reg == '0) || (first_reg >= n_reg))
                    begin
                        done_reg    <= 1'b1;
                        density_reg <= '0;
                        hit_reg     <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FETCH_HI;
                    end
                end
                S_FETCH_HI:
                begin
                    state_reg <= S_FETCH_LO;
                end
                S_FETCH_LO:
                begin
                    x2_reg    <= e_rd_reg;
                    y2_reg    <= flavor_reg ? anu_rd_reg : nu_rd_reg;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    // magnitudes and combined sign of the three differences
                    y1_reg  <= y1_sel;
                    dy_reg  <= (y2_reg < y1_sel) ? (y1_sel - y2_reg) : (y2_reg - y1_sel);
                    num_reg <= (e_reg < e_rd_reg) ? (e_rd_reg - e_reg) : (e_reg - e_rd_reg);
                    den_reg <= (x2_reg < e_rd_reg) ? (e_rd_reg - x2_reg) : (x2_reg - e_rd_reg);
                    neg_reg <= (y2_reg < y1_sel) ^ (e_reg < e_rd_reg) ^ (x2_reg < e_rd_reg);
                    state_reg <= S_START;
                end
                S_START:
                begin
                    // equal bracketing energies give a zero quotient
                    if (den_reg == '0)
                    begin
                        qz_reg    <= 1'b1;
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        qz_reg    <= 1'b0;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (md_res.done)
                        state_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    done_reg    <= 1'b1;
                    density_reg <= res_val;
                    hit_reg     <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign density = tsi_pkg::PORT_W'(density_reg);
    assign hit     = hit_reg;

    `ASSERT_CLK(a_done_idle, clk, rst_n, done_reg |-> (state_reg == S_IDLE), "result while busy")
    `ASSERT_CLK(a_hit_from_final, clk, rst_n, done_reg && hit_reg |-> $past(state_reg == S_FINAL), "stray hit")
    `ASSERT_CLK(a_search_bound, clk, rst_n, (state_reg == S_SEARCH_RD || state_reg == S_SEARCH_CMP) |-> (({1'b0, first_reg} + {1'b0, count_reg}) <= {1'b0, n_reg}), "search window past count")
    `ASSERT_NEVER(a_no_md_done_idle, clk, rst_n, md_res.done && (state_reg != S_WAIT), "stray arithmetic done")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tabulated spectrum interpolator: node loads and
// lookups go in over the start/busy port, every lookup answer is predicted by
// an in-bench lower-bound search and linear interpolation and checked field by
// field as it leaves on the done strobe
// ----------------------------------------------------------------------------
module tb;

    import tsi_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int MAX_GAP        = 19;
    // settle time, longer than a full table lookup
    localparam int SETTLE_CYCLES  = 160;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 20;
    localparam int PHASE_REQUESTS = 36;

    localparam logic FLAVOR_NEUTRINO     = 1'b0;
    localparam logic FLAVOR_ANTINEUTRINO = 1'b1;

    // index 3 has no register behind it, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [CFG_DATA_W-1:0] COUNT_MAX = '1;

    // energy orderings used when a table is loaded
    localparam int SHAPE_SORTED   = 0;
    localparam int SHAPE_REPEATS  = 1;
    localparam int SHAPE_UNSORTED = 2;

    localparam logic [ISO_W-1:0] TABLE_ISOS [ISOTOPES] = '{ISO_K40, ISO_TH232, ISO_U238};

    // a quotient beyond this is clipped before the add, the result saturates anyway
    localparam logic [63:0] QUOT_CAP    = 64'd1 << 50;
    localparam longint      DENSITY_TOP = longint'((64'd1 << DENSITY_BITS) - 1);

    typedef struct packed {
        logic [PORT_W-1:0] density;
        logic              hit;
    } lookup_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: private copy of the three tables and count registers, and the
    // queue of lookup answers still owed by the block
    // ------------------------------------------------------------------------
    class spectrum_scoreboard;
        bit [PORT_W-1:0]     node_energy  [ISOTOPES][TABLE_DEPTH];
        bit [PORT_W-1:0]     node_density [ISOTOPES][2][TABLE_DEPTH];
        bit [CFG_DATA_W-1:0] entries      [ISOTOPES];
        lookup_result_t      awaited [$];
        int                  errors;

        function int pending();
            return awaited.size();
        endfunction

        function void set_entries(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_POTASSIUM_ENTRIES: entries[ISO_K40]   = value;
                REG_THORIUM_ENTRIES:   entries[ISO_TH232] = value;
                REG_URANIUM_ENTRIES:   entries[ISO_U238]  = value;
                default: ;
            endcase
        endfunction

        // lower-bound search, then y1 + (y2 - y1) * (e - x1) / (x2 - x1)
        function lookup_result_t interpolate(logic [ISO_W-1:0] iso, logic flav,
                                             logic [PORT_W-1:0] query);
            lookup_result_t   r;
            int unsigned      live, first, count, half, mid;
            logic [PORT_W-1:0] x1, x2, y1, y2;
            logic [63:0]      dy, dx, span, q;
            bit               flip;
            longint           sum;
            r.density = '0;
            r.hit     = 1'b0;
            if (iso == ISO_NONE)
                return r;
            live  = (int'(entries[iso]) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries[iso]);
            first = 0;
            count = live;
            while (count > 0)
            begin
                half = count / 2;
                mid  = first + half;
                if (node_energy[iso][mid] < query)
                begin
                    first = mid + 1;
                    count = count - half - 1;
                end
                else
                    count = half;
            end
            if (first == 0 || first >= live)
                return r;
            x1 = node_energy[iso][first - 1];
            x2 = node_energy[iso][first];
            y1 = node_density[iso][flav][first - 1];
            y2 = node_density[iso][flav][first];
            dy   = (y2 < y1) ? 64'(y1 - y2) : 64'(y2 - y1);
            dx   = (query < x1) ? 64'(x1 - query) : 64'(query - x1);
            span = (x2 < x1) ? 64'(x1 - x2) : 64'(x2 - x1);
            flip = (y2 < y1) ^ (query < x1) ^ (x2 < x1);
            if (span == 0)
                q = '0;
            else
            begin
                q = (dy * dx) / span;
                if (q > QUOT_CAP)
                    q = QUOT_CAP;
            end
            sum = flip ? longint'(y1) - longint'(q) : longint'(y1) + longint'(q);
            if (sum < 0)
                sum = 0;
            else if (sum > DENSITY_TOP)
                sum = DENSITY_TOP;
            r.density = sum[PORT_W-1:0];
            r.hit     = 1'b1;
            return r;
        endfunction

        function void note_request(logic f, logic [ISO_W-1:0] iso, logic flav,
                                   logic [IDX_PORT_W-1:0] idx, logic [PORT_W-1:0] e,
                                   logic [PORT_W-1:0] nu, logic [PORT_W-1:0] anti);
            if (f == FUNC_LOOKUP)
                awaited.push_back(interpolate(iso, flav, e));
            else if (iso != ISO_NONE)
            begin
                node_energy[iso][idx]                       = e;
                node_density[iso][FLAVOR_NEUTRINO][idx]     = nu;
                node_density[iso][FLAVOR_ANTINEUTRINO][idx] = anti;
            end
        endfunction

        function void check_result(logic [PORT_W-1:0] got_density, logic got_hit);
            lookup_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result with no lookup pending: density %h hit %b", got_density, got_hit);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got_density !== want.density)
            begin
                $error("density mismatch: expected %h, actual %h", want.density, got_density);
                errors++;
            end
            if (got_hit !== want.hit)
            begin
                $error("hit mismatch: expected %b, actual %b", want.hit, got_hit);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block's ports, all known from time zero
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  start                = 1'b0;
    logic                  busy;
    logic                  func                 = FUNC_LOAD;
    logic [ISO_W-1:0]      isotope              = ISO_K40;
    logic                  flavor               = FLAVOR_NEUTRINO;
    logic [IDX_PORT_W-1:0] entry_index          = '0;
    logic [PORT_W-1:0]     energy               = '0;
    logic [PORT_W-1:0]     neutrino_density     = '0;
    logic [PORT_W-1:0]     antineutrino_density = '0;
    logic                  done;
    logic [PORT_W-1:0]     density;
    logic                  hit;
    logic                  cfg_valid            = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index            = '0;
    logic [CFG_DATA_W-1:0] cfg_data             = '0;

    always #HALF_PERIOD clk = ~clk;

    tabulated_spectrum_interpolator dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .func                 (func),
        .isotope              (isotope),
        .flavor               (flavor),
        .entry_index          (entry_index),
        .energy               (energy),
        .neutrino_density     (neutrino_density),
        .antineutrino_density (antineutrino_density),
        .done                 (done),
        .density              (density),
        .hit                  (hit),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    spectrum_scoreboard sb = new;

    // stimulus-side bookkeeping: a count may only cover nodes already written,
    // so the search never touches an unwritten node
    bit          node_written   [ISOTOPES][TABLE_DEPTH];
    int unsigned written_prefix [ISOTOPES];
    int          gap_limit = MAX_GAP;

    // results cannot be held off, so every done cycle is checked at its edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(density, hit);
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // one request: optional pause until all answers are in, a random gap, then
    // hold start until an edge with busy low takes it
    task automatic send_request(input logic f, input logic [ISO_W-1:0] iso, input logic flav,
                                input logic [IDX_PORT_W-1:0] idx, input logic [PORT_W-1:0] e,
                                input logic [PORT_W-1:0] nu, input logic [PORT_W-1:0] anti);
        int gap;
        gap = $urandom_range(0, gap_limit);
        if ($urandom_range(0, 47) == 0)
        begin
            // drain: nothing new goes in until every lookup has answered
            start <= 1'b0;
            @(posedge clk);
            while (sb.pending() != 0)
                @(posedge clk);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func                 <= f;
        isotope              <= iso;
        flavor               <= flav;
        entry_index          <= idx;
        energy               <= e;
        neutrino_density     <= nu;
        antineutrino_density <= anti;
        start                <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(f, iso, flav, idx, e, nu, anti);
        if (f == FUNC_LOAD && iso != ISO_NONE)
        begin
            node_written[iso][idx] = 1'b1;
            while (written_prefix[iso] < TABLE_DEPTH && node_written[iso][written_prefix[iso]])
                written_prefix[iso]++;
        end
    endtask

    // block idle: every answer in, then enough cycles for any lookup in flight
    task automatic quiesce();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // count registers change only while the block is idle
    task automatic set_counts(input logic [CFG_DATA_W-1:0] k40, input logic [CFG_DATA_W-1:0] th232,
                              input logic [CFG_DATA_W-1:0] u238, input bit poke_spare);
        logic [CFG_IDX_W-1:0]  regs [$];
        logic [CFG_DATA_W-1:0] vals [$];
        quiesce();
        regs = '{REG_POTASSIUM_ENTRIES, REG_THORIUM_ENTRIES, REG_URANIUM_ENTRIES};
        vals = '{k40, th232, u238};
        if (poke_spare)
        begin
            regs.push_back(REG_SPARE);
            vals.push_back(COUNT_MAX);
        end
        foreach (regs[i])
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_entries(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // densities lean on the extremes now and then
    function automatic logic [PORT_W-1:0] rand_density();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // write nodes 0..size-1 of one table
    task automatic load_table(input logic [ISO_W-1:0] iso, input int unsigned size,
                              input int shape);
        logic [PORT_W-1:0] levels [$];
        levels = {};
        repeat (size) levels.push_back($urandom());
        if (shape != SHAPE_UNSORTED)
            levels.sort();
        if (shape == SHAPE_REPEATS)
        begin
            for (int j = 1; j < levels.size(); j++)
                if ($urandom_range(0, 2) == 0)
                    levels[j] = levels[j - 1];
        end
        for (int j = 0; j < levels.size(); j++)
            send_request(FUNC_LOAD, iso, 1'($urandom_range(0, 1)), IDX_PORT_W'(j), levels[j],
                         rand_density(), rand_density());
    endtask

    // lookup aimed mostly inside a bracket, else on nodes, edges or anywhere
    task automatic issue_lookup();
        logic [ISO_W-1:0]  iso;
        logic [PORT_W-1:0] query;
        int unsigned       live, j, pick;
        longint unsigned   lo, hi;
        iso  = ($urandom_range(0, 24) == 0) ? ISO_NONE : TABLE_ISOS[$urandom_range(0, ISOTOPES - 1)];
        live = 0;
        if (iso != ISO_NONE)
            live = (int'(sb.entries[iso]) > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.entries[iso]);
        pick  = $urandom_range(0, 99);
        query = $urandom();
        if (live >= 2 && pick < 55)
        begin
            j  = $urandom_range(1, live - 1);
            lo = 64'(sb.node_energy[iso][j - 1]);
            hi = 64'(sb.node_energy[iso][j]);
            if (lo > hi)
            begin
                lo = hi;
                hi = 64'(sb.node_energy[iso][j - 1]);
            end
            query = PORT_W'(lo + longint'($urandom()) % (hi - lo + 1));
        end
        else if (live >= 1 && pick < 70)
            query = sb.node_energy[iso][$urandom_range(0, live - 1)];
        else if (live >= 1 && pick < 82)
        begin
            // one below, on or one above the first or the last node
            j     = ($urandom_range(0, 1) != 0) ? 0 : live - 1;
            query = sb.node_energy[iso][j] + PORT_W'($urandom_range(0, 2)) - 1;
        end
        else if (pick < 90)
            query = ($urandom_range(0, 1) != 0) ? '1 : '0;
        send_request(FUNC_LOOKUP, iso, 1'($urandom_range(0, 1)), IDX_PORT_W'($urandom()), query,
                     $urandom(), $urandom());
    endtask

    // ------------------------------------------------------------------------
    // watchdog: ends the run after too long with no request, result or write
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || done || (cfg_valid && cfg_ready)))
                stalled = 0;
            else
                stalled++;
        end
        $display("FAIL tabulated_spectrum_interpolator");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int                    big;
        int                    shape;
        int unsigned           fresh  [ISOTOPES];
        logic [CFG_DATA_W-1:0] counts [ISOTOPES];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tables after reset, isotope code three both ways
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_NEUTRINO, '0, '0, '0, '0);
        send_request(FUNC_LOOKUP, ISO_NONE, FLAVOR_ANTINEUTRINO, '1, '1, '1, '1);
        send_request(FUNC_LOAD, ISO_NONE, FLAVOR_ANTINEUTRINO, '1, '1, '1, '1);
        send_request(FUNC_LOOKUP, ISO_U238, FLAVOR_NEUTRINO, '0, 32'd1234, '0, '0);

        // small potassium table with a repeated energy and extreme densities
        send_request(FUNC_LOAD, ISO_K40, FLAVOR_NEUTRINO, 10'd0, 32'd0, '0, '1);
        send_request(FUNC_LOAD, ISO_K40, FLAVOR_NEUTRINO, 10'd1, 32'd1000, '1, '0);
        send_request(FUNC_LOAD, ISO_K40, FLAVOR_NEUTRINO, 10'd2, 32'd1000, 32'h1234_5678, 32'd5);
        send_request(FUNC_LOAD, ISO_K40, FLAVOR_NEUTRINO, 10'd3, '1, '1, '1);
        set_counts(11'd4, 11'd0, 11'd0, 1'b1);

        // on the first node, rising and falling brackets, on a repeated
        // energy, and right at the top of the energy range
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_NEUTRINO, '0, 32'd0, '0, '0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_NEUTRINO, '0, 32'd500, '0, '0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_ANTINEUTRINO, '0, 32'd500, '0, '0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_NEUTRINO, '0, 32'd1000, '0, '0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_ANTINEUTRINO, '0, 32'd1001, '0, '0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_NEUTRINO, '0, '1, '0, '0);

        // shorter count: the top query now lies above the last node
        set_counts(11'd3, 11'd0, 11'd0, 1'b0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_NEUTRINO, '0, '1, '0, '0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_ANTINEUTRINO, '0, 32'd1000, '0, '0);

        // a single node never brackets anything
        set_counts(11'd1, 11'd0, 11'd0, 1'b0);
        send_request(FUNC_LOOKUP, ISO_K40, FLAVOR_NEUTRINO, '0, 32'd2000, '0, '0);

        // random phases: reload some tables, pick counts, then a run of lookups
        // with a little load noise mixed in. phase 1 fills one table completely,
        // which opens counts at and above the table depth
        big = $urandom_range(0, ISOTOPES - 1);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            gap_limit = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            if (p == 1)
                load_table(TABLE_ISOS[big], TABLE_DEPTH, SHAPE_SORTED);
            for (int k = 0; k < ISOTOPES; k++)
            begin
                fresh[k] = 0;
                if (!((p == 1 || p == 2) && k == big) && $urandom_range(0, 2) != 0)
                begin
                    fresh[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
                                                           : $urandom_range(1, 12);
                    case ($urandom_range(0, 6))
                        0, 1:    shape = SHAPE_REPEATS;
                        2:       shape = SHAPE_UNSORTED;
                        default: shape = SHAPE_SORTED;
                    endcase
                    load_table(TABLE_ISOS[k], fresh[k], shape);
                end
                if (p == 1 && k == big)
                    counts[k] = COUNT_MAX;
                else if (p == 2 && k == big)
                    counts[k] = CFG_DATA_W'(TABLE_DEPTH);
                else if (written_prefix[k] == TABLE_DEPTH && $urandom_range(0, 3) == 0)
                    counts[k] = CFG_DATA_W'($urandom_range(TABLE_DEPTH, COUNT_MAX));
                else if (fresh[k] != 0 && $urandom_range(0, 3) != 0)
                    counts[k] = CFG_DATA_W'(fresh[k]);
                else
                    counts[k] = CFG_DATA_W'($urandom_range(0, written_prefix[k]));
            end
            set_counts(counts[0], counts[1], counts[2], 1'b0);
            repeat (PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_request(FUNC_LOAD, ISO_W'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 1)), IDX_PORT_W'($urandom()),
                                 $urandom(), rand_density(), rand_density());
                else
                    issue_lookup();
            end
        end

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS tabulated_spectrum_interpolator");
        else
            $display("FAIL tabulated_spectrum_interpolator");
        $finish;
    end

endmodule

### tabulated_spectrum_interpolator.f
+incdir+hw/rtl
hw/rtl/tsi_pkg.sv
hw/rtl/tsi_muldiv.sv
hw/rtl/tabulated_spectrum_interpolator.sv
tb/sv/tb.sv
